[rtl/i2cm_pkg.sv]
// shared types and constants of the i2c bit-level master
// command codes, classified command items, engine phases and result items
// no dependencies
package i2cm_pkg;

  // operation codes on the input port
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // reset value of the half-period register
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd4;

  // bits in one byte transfer
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // command after classification by the front end
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  // one classified tick item
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // one result item
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       nack;
    logic [7:0] rx_byte;
    logic       rejected;
  } res_t;

  // bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_REL_SDA,
    PH_ST_REL_SCL,
    PH_ST_SDA_LOW,
    PH_ST_SCL_LOW,
    PH_WR_DATA,
    PH_WR_HIGH,
    PH_WR_ACK_SETUP,
    PH_WR_ACK_HIGH,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_RD_ACK_SETUP,
    PH_RD_ACK_HIGH,
    PH_SP_WAIT,
    PH_SP_HIGH
  } phase_t;

endpackage

[rtl/i2cm_front.sv]
// front end: decodes the operation code and queues classified items
// two-entry queue in front of the bus engine
// depends on i2cm_pkg
module i2cm_front import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [2:0] operation,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  output logic       item_valid,
  output item_t      item,
  input  logic       item_take
);

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_dec;
  logic       do_push;
  logic       do_pop;

  // classify the operation, unknown codes act as no command
  always_comb begin
    unique case (operation)
      OP_START: cmd_dec = CMD_START;
      OP_STOP:  cmd_dec = CMD_STOP;
      OP_WRITE: cmd_dec = CMD_WRITE;
      OP_READ:  cmd_dec = CMD_READ;
      default:  cmd_dec = CMD_NONE;
    endcase
  end

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;
  assign item       = entries[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= '{cmd: cmd_dec, tx_byte: tx_byte, send_ack: send_ack,
                           sda_in: sda_in};
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/i2cm_engine.sv]
// back end: bus sequencer that runs one tick item per transfer
// drives scl and sda levels, shifts bytes, samples acknowledge
// depends on i2cm_pkg
module i2cm_engine import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        fire,
  input  item_t       item,
  output res_t        res
);

  logic [15:0] half_period;
  phase_t      phase;
  phase_t      phase_next;
  logic [3:0]  bit_count;
  logic [3:0]  bit_count_next;
  logic [7:0]  shift_reg;
  logic [7:0]  shift_reg_next;
  logic [15:0] delay_count;
  logic [15:0] delay_count_next;
  logic        scl_level;
  logic        scl_level_next;
  logic        sda_level;
  logic        sda_level_next;
  logic        ack_choice;
  logic        ack_choice_next;
  logic        nack_flag;
  logic        nack_flag_next;
  logic [7:0]  rx_hold;
  logic [7:0]  rx_hold_next;
  logic        done;

  logic [15:0] limit;
  logic [16:0] cnt;
  logic        step;
  logic        busy;
  logic [3:0]  bit_inc;

  // delay step timing
  assign limit   = (half_period == 16'd0) ? 16'd1 : half_period;
  assign cnt     = {1'b0, delay_count} + 17'd1;
  assign step    = (cnt >= {1'b0, limit});
  assign busy    = (phase != PH_IDLE);
  assign bit_inc = bit_count + 4'd1;

  // next phase
  always_comb begin
    phase_next = phase;
    if (busy) begin
      if (step) begin
        unique case (phase)
          PH_ST_REL_SDA:   phase_next = PH_ST_REL_SCL;
          PH_ST_REL_SCL:   phase_next = PH_ST_SDA_LOW;
          PH_ST_SDA_LOW:   phase_next = PH_ST_SCL_LOW;
          PH_ST_SCL_LOW:   phase_next = PH_WR_DATA;
          PH_WR_DATA:      phase_next = PH_WR_HIGH;
          PH_WR_HIGH:      phase_next = (bit_inc < BYTE_BITS) ? PH_WR_DATA : PH_WR_ACK_SETUP;
          PH_WR_ACK_SETUP: phase_next = PH_WR_ACK_HIGH;
          PH_WR_ACK_HIGH:  phase_next = PH_IDLE;
          PH_RD_LOW:       phase_next = PH_RD_HIGH;
          PH_RD_HIGH:      phase_next = (bit_inc < BYTE_BITS) ? PH_RD_LOW : PH_RD_ACK_SETUP;
          PH_RD_ACK_SETUP: phase_next = PH_RD_ACK_HIGH;
          PH_RD_ACK_HIGH:  phase_next = PH_IDLE;
          PH_SP_WAIT:      phase_next = PH_SP_HIGH;
          PH_SP_HIGH:      phase_next = PH_IDLE;
          default:         phase_next = PH_IDLE;
        endcase
      end
    end else begin
      unique case (item.cmd)
        CMD_START: phase_next = PH_ST_REL_SDA;
        CMD_STOP:  phase_next = PH_SP_WAIT;
        CMD_WRITE: phase_next = PH_WR_DATA;
        CMD_READ:  phase_next = PH_RD_LOW;
        default:   phase_next = PH_IDLE;
      endcase
    end
  end

  // pin levels, shifter, counters and flags
  always_comb begin
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    delay_count_next = delay_count;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    ack_choice_next  = ack_choice;
    nack_flag_next   = nack_flag;
    rx_hold_next     = rx_hold;
    done             = 1'b0;
    if (busy) begin
      if (step) begin
        delay_count_next = 16'd0;
        unique case (phase)
          PH_ST_REL_SDA: scl_level_next = 1'b1;
          PH_ST_REL_SCL: sda_level_next = 1'b0;
          PH_ST_SDA_LOW: scl_level_next = 1'b0;
          PH_ST_SCL_LOW: sda_level_next = shift_reg[7];
          PH_WR_DATA:    scl_level_next = 1'b1;
          PH_WR_HIGH: begin
            scl_level_next = 1'b0;
            shift_reg_next = {shift_reg[6:0], 1'b0};
            bit_count_next = bit_inc;
            sda_level_next = (bit_inc < BYTE_BITS) ? shift_reg[6] : 1'b1;
          end
          PH_WR_ACK_SETUP: scl_level_next = 1'b1;
          PH_WR_ACK_HIGH: begin
            nack_flag_next = item.sda_in;
            scl_level_next = 1'b0;
            sda_level_next = 1'b0;
            done           = 1'b1;
          end
          PH_RD_LOW: scl_level_next = 1'b1;
          PH_RD_HIGH: begin
            shift_reg_next = {shift_reg[6:0], item.sda_in};
            scl_level_next = 1'b0;
            bit_count_next = bit_inc;
            if (!(bit_inc < BYTE_BITS)) begin
              sda_level_next = ~ack_choice;
            end
          end
          PH_RD_ACK_SETUP: scl_level_next = 1'b1;
          PH_RD_ACK_HIGH: begin
            scl_level_next = 1'b0;
            sda_level_next = 1'b0;
            rx_hold_next   = shift_reg;
            done           = 1'b1;
          end
          PH_SP_WAIT: scl_level_next = 1'b1;
          PH_SP_HIGH: begin
            sda_level_next = 1'b1;
            done           = 1'b1;
          end
          default: ;
        endcase
      end else begin
        delay_count_next = cnt[15:0];
      end
    end else if (item.cmd != CMD_NONE) begin
      delay_count_next = 16'd0;
      bit_count_next   = 4'd0;
      unique case (item.cmd)
        CMD_START: begin
          shift_reg_next = item.tx_byte;
          sda_level_next = 1'b1;
        end
        CMD_WRITE: begin
          shift_reg_next = item.tx_byte;
          sda_level_next = item.tx_byte[7];
        end
        CMD_READ: begin
          shift_reg_next  = 8'd0;
          ack_choice_next = item.send_ack;
          sda_level_next  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result of this tick
  assign res = '{scl_out: scl_level_next, sda_out: sda_level_next,
                 busy_res: (phase_next != PH_IDLE), done_res: done,
                 nack: nack_flag_next, rx_byte: rx_hold_next,
                 rejected: busy && (item.cmd != CMD_NONE)};

  // delay register
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_write) begin
      half_period <= cfg_data;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= 4'd0;
      shift_reg   <= 8'd0;
      delay_count <= 16'd0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      ack_choice  <= 1'b0;
      nack_flag   <= 1'b0;
      rx_hold     <= 8'd0;
    end else if (fire) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      delay_count <= delay_count_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      ack_choice  <= ack_choice_next;
      nack_flag   <= nack_flag_next;
      rx_hold     <= rx_hold_next;
    end
  end

endmodule

[rtl/i2cm_res_queue.sv]
// result queue between the bus engine and the result port
// two entries, so the engine keeps running while one result waits
// depends on i2cm_pkg
module i2cm_res_queue import i2cm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  res_t wr_res,
  output logic q_full,
  output logic q_empty,
  input  logic rd_en,
  output res_t rd_res
);

  res_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_res  = entries[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_res;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/i2c_bit_level_master_core.sv]
// I2C master bit engine, one pin-sequencer tick per input transfer.
// Input side is a queue: a transfer happens when push is high and full is low.
// Each input item is one tick; operation selects none, start plus address,
// stop, write byte or read byte (with send_ack for the ninth bit), and
// sda_in is the SDA level sampled on that tick.
// Result side is a queue: while empty is low the oldest result is on the
// result ports; a transfer happens when pop is high and empty is low.
// Every input item gives exactly one result item, in order.
// An input transfer is registered in the front queue, then the engine result
// for it is registered into the result queue. Throughput is one item per
// cycle while the result queue is not full, set by the engine sequencer step.
// A stalled receiver fills the 2-entry result queue, then the engine stops
// and the 2-entry input queue fills and raises full.
// The config channel (cfg_valid/cfg_ready/cfg_data) writes the half-period
// tick count; cfg_ready is always high. Write it only while idle.
// Synchronous reset clears both queues, releases SCL and SDA, sets the
// half-period to 4 ticks and clears nack and rx_byte.
// depends on i2cm_pkg, i2cm_front, i2cm_engine, i2cm_res_queue
module i2c_bit_level_master_core import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [7:0]  tx_byte,
  input  logic        send_ack,
  input  logic        sda_in,
  output logic        empty,
  input  logic        pop,
  output logic        scl_out,
  output logic        sda_out,
  output logic        busy_res,
  output logic        done_res,
  output logic        nack,
  output logic [7:0]  rx_byte,
  output logic        rejected,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  item_t item;
  logic  item_valid;
  logic  res_full;
  logic  fire;
  res_t  eng_res;
  res_t  out_res;

  assign cfg_ready = 1'b1;
  assign fire      = item_valid && !res_full;

  // command front end
  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .tx_byte    (tx_byte),
    .send_ack   (send_ack),
    .sda_in     (sda_in),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (fire)
  );

  // bus sequencer
  i2cm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .res       (eng_res)
  );

  // result queue
  i2cm_res_queue u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fire),
    .wr_res  (eng_res),
    .q_full  (res_full),
    .q_empty (empty),
    .rd_en   (pop),
    .rd_res  (out_res)
  );

  // result ports
  assign scl_out  = out_res.scl_out;
  assign sda_out  = out_res.sda_out;
  assign busy_res = out_res.busy_res;
  assign done_res = out_res.done_res;
  assign nack     = out_res.nack;
  assign rx_byte  = out_res.rx_byte;
  assign rejected = out_res.rejected;

endmodule
